// ===== rtl/core/arle_pkg.sv =====
// Shared types and constants of the animation RLE decoder.
`timescale 1ns / 1ps
package arle_pkg;

  localparam int CFG_W     = 13;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int POS_W     = 42;
  localparam logic [15:0] HDR_EXT_BIT = 16'h0008;
  localparam logic [7:0]  CODE_SKIP   = 8'h00;
  localparam logic [7:0]  CODE_EOL    = 8'hFF;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_ADD   = 2'd1,
    OP_WRITE = 2'd2,
    OP_DONE  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] val;
    logic [7:0]  cnt;
    logic [31:0] argb;
  } op_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W:0] lim;
    lim = (POS_W+1)'(64'sd1 << 40);
    if (v > lim) begin
      sat_pos = POS_W'(lim);
    end else if (v < -lim) begin
      sat_pos = POS_W'(-lim);
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/arle_in_if.sv =====
// Input byte channel of the animation RLE decoder.
`timescale 1ns / 1ps
interface arle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;
  modport source (output valid, data_byte, chunk_start, input ready);
  modport sink (input valid, data_byte, chunk_start, output ready);
endinterface

// ===== rtl/core/arle_out_if.sv =====
// Pixel-write result channel of the animation RLE decoder.
`timescale 1ns / 1ps
interface arle_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_index;
  logic [7:0]  pixel_count;
  logic [31:0] argb;
  logic        frame_done;
  logic        out_of_range;
  modport source (output valid, pixel_index, pixel_count, argb, frame_done, out_of_range,
                  input ready);
  modport sink (input valid, pixel_index, pixel_count, argb, frame_done, out_of_range,
                output ready);
endinterface

// ===== rtl/core/animation_rle_32bpp_decoder.sv =====
// Top level of the 32-bit animation RLE decoder.
//
//  channel  dir  handshake        payload
//  in_bus   in   valid/ready      data_byte[7:0], chunk_start
//  out_bus  out  valid/ready      pixel_index[23:0], pixel_count[7:0], argb[31:0],
//                                 frame_done, out_of_range
//  cfg      in   cfg_we           cfg_idx (0 width, 1 height), cfg_data[12:0]
//
// One byte per clock is taken while the op queue has room; each byte yields
// at most one op, and the write stage retires one op per clock while the
// output is not stalled, so the sustained rate is one byte per cycle. A
// result is registered when its op is popped from the queue head; a fill is
// one transfer. Reset (rst_n low, synchronous) empties the queue and output
// register and returns the parser to waiting for a chunk start. A stalled
// output fills the 4-entry queue, and only then is in_bus.ready dropped.
// Config takes effect once it is held in the frame size registers.
`timescale 1ns / 1ps
module animation_rle_32bpp_decoder import arle_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  arle_in_if.sink          in_bus,
  arle_out_if.source       out_bus,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] eff_w, eff_h;
  logic             acc;
  logic             op_push, pop;
  op_t              push_op, head;
  q_stat_t          qstat;

  // Clamp registers to the configured maximum frame size.
  assign eff_w = (int'(width_r) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_r;
  assign eff_h = (int'(height_r) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_r;

  // Conservative: accept only when a queue slot is guaranteed.
  assign in_bus.ready = !qstat.full;
  assign acc          = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  arle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .data_byte   (in_bus.data_byte),
    .chunk_start (in_bus.chunk_start),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .op_push     (op_push),
    .op          (push_op)
  );

  arle_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .stat    (qstat)
  );

  arle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .head       (head),
    .head_valid (qstat.valid),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

// ===== rtl/core/arle_front.sv =====
// Byte parser: header, line and code decoding into position, write and done ops.
`timescale 1ns / 1ps
module arle_front import arle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       data_byte,
  input  logic             chunk_start,
  input  logic [CFG_W-1:0] eff_w,
  input  logic [CFG_W-1:0] eff_h,
  output logic             op_push,
  output op_t              op
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_SIZE, PH_HDR, PH_EXT, PH_LSKIP, PH_CODE, PH_SKIP, PH_PIX
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [15:0] hword_r, hword_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] lines_r, lines_nxt;
  logic [30:0] rb_r, rb_nxt;
  logic        rb_load_r, rb_load_nxt;
  logic [28:0] prod_r;
  logic [7:0]  run_r, run_nxt;
  logic        fill_r, fill_nxt;
  logic [1:0]  pbc_r, pbc_nxt;
  logic [23:0] part_r, part_nxt;
  logic [30:0] rb_eff;
  logic [15:0] lines_dec;
  logic [31:0] argb_w;

  assign rb_eff    = rb_load_r ? {2'b0, prod_r} : rb_r;
  assign lines_dec = lines_r - 16'd1;
  assign argb_w    = {part_r[23:16], data_byte, part_r[7:0], part_r[15:8]};

  always_comb begin
    phase_nxt   = phase_r;
    hcnt_nxt    = hcnt_r;
    hword_nxt   = hword_r;
    start_nxt   = start_r;
    lines_nxt   = lines_r;
    rb_nxt      = rb_load_r ? {2'b0, prod_r} : rb_r;
    rb_load_nxt = 1'b0;
    run_nxt     = run_r;
    fill_nxt    = fill_r;
    pbc_nxt     = pbc_r;
    part_nxt    = part_r;
    op_push     = 1'b0;
    op          = '{kind: OP_SET, val: '0, cnt: '0, argb: '0};
    if (acc) begin
      if (chunk_start) begin
        phase_nxt = PH_SIZE;
        hcnt_nxt  = 4'd1;
      end else begin
        unique case (phase_r)
          PH_WAIT: ;
          PH_SIZE: begin
            hcnt_nxt = hcnt_r + 4'd1;
            if (hcnt_r >= 4'd3) begin
              phase_nxt = PH_HDR;
              hcnt_nxt  = 4'd0;
            end
          end
          PH_HDR: begin
            hword_nxt = {hword_r[7:0], data_byte};
            hcnt_nxt  = hcnt_r + 4'd1;
            if (hcnt_r >= 4'd1) begin
              hcnt_nxt = 4'd0;
              if ((hword_nxt & HDR_EXT_BIT) != 16'd0) begin
                phase_nxt = PH_EXT;
              end else begin
                start_nxt = 16'd0;
                lines_nxt = {3'b0, eff_h};
                rb_nxt    = '0;
                if (eff_h == '0) begin
                  op_push   = 1'b1;
                  op.kind   = OP_DONE;
                  phase_nxt = PH_WAIT;
                end else begin
                  phase_nxt = PH_LSKIP;
                end
              end
            end
          end
          PH_EXT: begin
            if (hcnt_r <= 4'd1) start_nxt = {start_r[7:0], data_byte};
            if (hcnt_r == 4'd4 || hcnt_r == 4'd5) lines_nxt = {lines_r[7:0], data_byte};
            hcnt_nxt = hcnt_r + 4'd1;
            if (hcnt_r >= 4'd7) begin
              hcnt_nxt    = 4'd0;
              rb_load_nxt = 1'b1;   // row base = start line * width, next cycle
              if (lines_r == 16'd0) begin
                op_push   = 1'b1;
                op.kind   = OP_DONE;
                phase_nxt = PH_WAIT;
              end else begin
                phase_nxt = PH_LSKIP;
              end
            end
          end
          PH_LSKIP: begin
            op_push   = 1'b1;
            op.kind   = OP_SET;
            op.val    = {1'b0, rb_eff} + {24'd0, data_byte} - 32'd1;
            phase_nxt = PH_CODE;
          end
          PH_SKIP: begin
            op_push   = 1'b1;
            op.kind   = OP_ADD;
            op.val    = {24'd0, data_byte};
            phase_nxt = PH_CODE;
          end
          PH_CODE: begin
            priority if (data_byte == CODE_SKIP) begin
              phase_nxt = PH_SKIP;
            end else if (data_byte == CODE_EOL) begin
              rb_nxt    = rb_eff + {18'd0, eff_w};
              lines_nxt = lines_dec;
              if (lines_dec == 16'd0) begin
                op_push   = 1'b1;
                op.kind   = OP_DONE;
                phase_nxt = PH_WAIT;
              end else begin
                phase_nxt = PH_LSKIP;
              end
            end else begin
              run_nxt   = data_byte[7] ? 8'd0 - data_byte : data_byte;
              fill_nxt  = data_byte[7];
              pbc_nxt   = 2'd0;
              phase_nxt = PH_PIX;
            end
          end
          PH_PIX: begin
            if (pbc_r != 2'd3) begin
              part_nxt = {part_r[15:0], data_byte};
              pbc_nxt  = pbc_r + 2'd1;
            end else begin
              pbc_nxt = 2'd0;
              op_push = 1'b1;
              op.kind = OP_WRITE;
              op.argb = argb_w;
              if (fill_r) begin
                op.cnt    = run_r;
                run_nxt   = 8'd0;
                phase_nxt = PH_CODE;
              end else begin
                op.cnt  = 8'd1;
                run_nxt = run_r - 8'd1;
                if (run_r == 8'd1) phase_nxt = PH_CODE;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 29'(start_r * eff_w);
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      hcnt_r    <= '0;
      hword_r   <= '0;
      start_r   <= '0;
      lines_r   <= '0;
      rb_r      <= '0;
      rb_load_r <= 1'b0;
      run_r     <= '0;
      fill_r    <= 1'b0;
      pbc_r     <= '0;
      part_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hcnt_r    <= hcnt_nxt;
      hword_r   <= hword_nxt;
      start_r   <= start_nxt;
      lines_r   <= lines_nxt;
      rb_r      <= rb_nxt;
      rb_load_r <= rb_load_nxt;
      run_r     <= run_nxt;
      fill_r    <= fill_nxt;
      pbc_r     <= pbc_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

// ===== rtl/core/arle_queue.sv =====
// Short op queue between the parser and the write stage.
`timescale 1ns / 1ps
module arle_queue import arle_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     head,
  output q_stat_t stat
);

  op_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign head       = mem_r[rp_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_op;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full && !pop |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.valid) else $error("queue underflow");

endmodule

// ===== rtl/core/arle_back.sv =====
// Write stage: tracks pixel position, range-checks and registers results.
`timescale 1ns / 1ps
module arle_back import arle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] eff_w,
  input  logic [CFG_W-1:0] eff_h,
  input  op_t              head,
  input  logic             head_valid,
  output logic             pop,
  arle_out_if.source       out_bus
);

  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic [25:0]             size_r;
  logic                    ov_r;
  logic [23:0]             idx_r;
  logic [7:0]              cnt_r;
  logic [31:0]             argb_r;
  logic                    done_r, oor_r;
  logic                    slot_free, emits;
  logic signed [POS_W:0]   sum_w;
  logic                    bad;

  assign slot_free = !ov_r || out_bus.ready;
  assign emits     = (head.kind == OP_WRITE) || (head.kind == OP_DONE);
  assign pop       = head_valid && (!emits || slot_free);

  always_comb begin
    sum_w   = '0;
    pos_nxt = pos_r;
    bad     = 1'b0;
    unique case (head.kind)
      OP_SET: pos_nxt = POS_W'($signed(head.val));
      OP_ADD: begin
        sum_w   = (POS_W+1)'(pos_r) + (POS_W+1)'(head.val) - (POS_W+1)'(1);
        pos_nxt = sat_pos(sum_w);
      end
      OP_WRITE: begin
        sum_w   = (POS_W+1)'(pos_r) + (POS_W+1)'(head.cnt);
        bad     = pos_r[POS_W-1] || (sum_w > $signed((POS_W+1)'(size_r)));
        pos_nxt = sat_pos(sum_w);
      end
      OP_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    size_r <= eff_w * eff_h;
    if (pop) pos_r <= pos_nxt;
    if (pop && emits) begin
      idx_r  <= (head.kind == OP_DONE) ? 24'd0 : pos_r[23:0];
      cnt_r  <= (head.kind == OP_DONE) ? 8'd0 : head.cnt;
      argb_r <= (head.kind == OP_DONE) ? 32'd0 : head.argb;
      done_r <= (head.kind == OP_DONE);
      oor_r  <= bad;
    end
    if (!rst_n) begin
      ov_r  <= 1'b0;
      pos_r <= '0;
    end else if (pop && emits) begin
      ov_r <= 1'b1;
    end else if (out_bus.ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_bus.valid        = ov_r;
  assign out_bus.pixel_index  = idx_r;
  assign out_bus.pixel_count  = cnt_r;
  assign out_bus.argb         = argb_r;
  assign out_bus.frame_done   = done_r;
  assign out_bus.out_of_range = oor_r;

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && done_r |-> cnt_r == 8'd0 && !oor_r && argb_r == 32'd0)
    else $error("done marker carries payload");
  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !done_r |-> cnt_r != 8'd0) else $error("write with zero count");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= $signed(POS_W'(64'sd1 << 40)) && pos_r >= -$signed(POS_W'(64'sd1 << 40)))
    else $error("position beyond saturation limit");
  a_pop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_bus.ready && head_valid && emits |-> !pop)
    else $error("result overwritten while held");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the 32-bit animation RLE decoder.
`timescale 1ns / 1ps

typedef struct packed {
  logic [23:0] pixel_index;
  logic [7:0]  pixel_count;
  logic [31:0] argb;
  logic        frame_done;
  logic        out_of_range;
} pixel_cmd_t;

typedef struct packed {
  logic [7:0] data;
  logic       start;
} rle_byte_t;

typedef enum int {
  ST_WAIT, ST_SIZE, ST_HDR, ST_EXT, ST_LSKIP, ST_CODE, ST_SKIP, ST_PIX
} parse_st_t;

class rle_scoreboard;
  localparam longint POS_SAT = longint'(1) << 40;
  localparam longint DIM_MAX = 4096;

  logic [12:0] width_reg = 13'd640;
  logic [12:0] height_reg = 13'd480;
  parse_st_t   st = ST_WAIT;
  int unsigned hdr_cnt = 0;
  logic [15:0] hdr_word = '0;
  logic [15:0] first_line = '0;
  logic [15:0] lines_todo = '0;
  longint      line_base = 0;
  longint      pos = 0;
  logic [7:0]  run_cnt = '0;
  bit          fill_run = 0;
  int unsigned pix_bytes = 0;
  logic [23:0] pix_acc = '0;
  pixel_cmd_t  pending[$];
  int          mismatches = 0;

  function longint clamp_pos(longint v);
    if (v > POS_SAT) return POS_SAT;
    if (v < -POS_SAT) return -POS_SAT;
    return v;
  endfunction

  function longint eff_w();
    return (width_reg > DIM_MAX) ? DIM_MAX : longint'(width_reg);
  endfunction

  function longint eff_h();
    return (height_reg > DIM_MAX) ? DIM_MAX : longint'(height_reg);
  endfunction

  function void push_write(logic [7:0] cnt, logic [31:0] argb);
    pixel_cmd_t c;
    c.pixel_index  = pos[23:0];
    c.pixel_count  = cnt;
    c.argb         = argb;
    c.frame_done   = 1'b0;
    c.out_of_range = (pos < 0) || (pos + longint'(cnt) > eff_w() * eff_h());
    pending.push_back(c);
    pos = clamp_pos(pos + longint'(cnt));
  endfunction

  function void push_done();
    pending.push_back('{frame_done: 1'b1, default: '0});
    st = ST_WAIT;
  endfunction

  function void open_lines();
    line_base = longint'(first_line) * eff_w();
    if (lines_todo == 0) push_done();
    else st = ST_LSKIP;
  endfunction

  // Advance the parser by one accepted byte.
  function void note_byte(logic [7:0] b, logic s);
    logic [31:0] argb;
    if (s) begin
      st = ST_SIZE;
      hdr_cnt = 1;
      return;
    end
    case (st)
      ST_SIZE: begin
        hdr_cnt++;
        if (hdr_cnt >= 4) begin
          st = ST_HDR;
          hdr_cnt = 0;
        end
      end
      ST_HDR: begin
        hdr_word = {hdr_word[7:0], b};
        hdr_cnt++;
        if (hdr_cnt >= 2) begin
          hdr_cnt = 0;
          if ((hdr_word & arle_pkg::HDR_EXT_BIT) != 0) begin
            st = ST_EXT;
          end else begin
            first_line = '0;
            lines_todo = 16'(eff_h());
            open_lines();
          end
        end
      end
      ST_EXT: begin
        if (hdr_cnt < 2) first_line = {first_line[7:0], b};
        else if (hdr_cnt == 4 || hdr_cnt == 5) lines_todo = {lines_todo[7:0], b};
        hdr_cnt++;
        if (hdr_cnt >= 8) begin
          hdr_cnt = 0;
          open_lines();
        end
      end
      ST_LSKIP: begin
        pos = clamp_pos(line_base + longint'(b) - 1);
        st = ST_CODE;
      end
      ST_SKIP: begin
        pos = clamp_pos(pos + longint'(b) - 1);
        st = ST_CODE;
      end
      ST_CODE: begin
        if (b == arle_pkg::CODE_SKIP) begin
          st = ST_SKIP;
        end else if (b == arle_pkg::CODE_EOL) begin
          line_base += eff_w();
          lines_todo = lines_todo - 16'd1;
          if (lines_todo == 0) push_done();
          else st = ST_LSKIP;
        end else begin
          fill_run = b[7];
          run_cnt = b[7] ? 8'(9'd256 - b) : b;
          pix_bytes = 0;
          st = ST_PIX;
        end
      end
      ST_PIX: begin
        if (pix_bytes < 3) begin
          pix_acc = {pix_acc[15:0], b};
          pix_bytes++;
        end else begin
          // bytes arrive a, b, g, r
          argb = {pix_acc[23:16], b, pix_acc[7:0], pix_acc[15:8]};
          pix_bytes = 0;
          if (fill_run) begin
            push_write(run_cnt, argb);
            run_cnt = '0;
            st = ST_CODE;
          end else begin
            run_cnt = run_cnt - 8'd1;
            if (run_cnt == 0) st = ST_CODE;
            push_write(8'd1, argb);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_cmd(pixel_cmd_t got);
    pixel_cmd_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected transfer: %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module testbench;
  import arle_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  arle_in_if  in_bus ();
  arle_out_if out_bus ();

  animation_rle_32bpp_decoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  rle_scoreboard sb = new();
  rle_byte_t     stream[$];
  int            bytes_sent = 0;
  bit            long_hold = 0;
  int            stall_cycles = 0;

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.chunk_start = 1'b0;
    out_bus.ready      = 1'b0;
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 3000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: random ready gaps, one long hold-off on request.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (long_hold) begin
        gap = 400;
        long_hold = 0;
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      sb.check_cmd('{out_bus.pixel_index, out_bus.pixel_count, out_bus.argb,
                     out_bus.frame_done, out_bus.out_of_range});
    end
  end

  // Push the byte queue out over in_bus, one transfer per byte.
  task automatic flush_stream();
    rle_byte_t item;
    int gap;
    while (stream.size() > 0) begin
      item = stream.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_bus.valid       <= 1'b1;
      in_bus.data_byte   <= item.data;
      in_bus.chunk_start <= item.start;
      do @(posedge clk); while (!in_bus.ready);
      sb.note_byte(item.data, item.start);
      bytes_sent++;
    end
  endtask

  task automatic put(logic [7:0] b, logic s = 1'b0);
    stream.push_back('{b, s});
  endtask

  task automatic put_pixel();
    repeat (4) put(8'($urandom()));
  endtask

  // Frame chunk: size, header, optional extension, then lines of codes.
  task automatic build_frame(bit ext, logic [15:0] line0, logic [15:0] nlines,
                             int max_ops);
    logic [15:0] hdr;
    int n;
    put(8'($urandom()), 1'b1);
    repeat (3) put(8'($urandom()));
    hdr = 16'($urandom());
    hdr[3] = ext;
    put(hdr[15:8]);
    put(hdr[7:0]);
    if (ext) begin
      put(line0[15:8]); put(line0[7:0]);
      put(8'($urandom())); put(8'($urandom()));
      put(nlines[15:8]); put(nlines[7:0]);
      put(8'($urandom())); put(8'($urandom()));
    end
    repeat (nlines) begin
      put(($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 4)));
      repeat ($urandom_range(0, max_ops)) begin
        case ($urandom_range(0, 5))
          0: begin
            put(CODE_SKIP);
            put(($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3)));
          end
          1, 2: begin
            // fill, occasionally the longest run
            put(($urandom_range(0, 9) == 0) ? 8'h80 : 8'($urandom_range(8'h81, 8'hFE)));
            put_pixel();
          end
          default: begin
            n = ($urandom_range(0, 99) == 0) ? 127 : $urandom_range(1, 3);
            put(8'(n));
            repeat (n) put_pixel();
          end
        endcase
      end
      put(CODE_EOL);
    end
  endtask

  // Truncated chunk or junk bytes, possibly with stray chunk starts.
  task automatic build_noise();
    repeat ($urandom_range(1, 12))
      put(8'($urandom()), ($urandom_range(0, 7) == 0));
  endtask

  // Idle: nothing pending, then let any resultless byte drain the pipe.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_frame_size(logic [12:0] w, logic [12:0] h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= CFG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.width_reg  = w;
    sb.height_reg = h;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_phase(int n_bytes, logic [15:0] max_line, logic [15:0] max_lines);
    int stop;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_frame(1'b1, 16'($urandom_range(0, max_line)),
                       16'($urandom_range(1, max_lines)), 3);
      flush_stream();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset frame size 640x480: extended header, idle bytes, restart.
    put(8'hA5); put(8'h5A);
    build_frame(1'b1, 16'd479, 16'd2, 3);
    build_frame(1'b1, 16'd0, 16'd0, 0);   // zero lines: done right after header
    flush_stream();
    build_frame(1'b1, 16'd3, 16'd2, 2);
    stream = stream[0:$-3];               // cut short, then restart
    build_frame(1'b1, 16'hFFFF, 16'd1, 2);
    flush_stream();
    drain();

    // Tiny frame; plain header walks all lines; edge pixel values.
    write_frame_size(13'd4, 13'd2);
    put(8'h00, 1'b1); put(8'h00); put(8'h00); put(8'h00);
    put(8'hFF); put(8'hF7);               // plain header, bit 3 clear
    put(8'h00);                           // line skip 0: position -1
    put(8'h01); repeat (4) put(8'hFF);
    put(8'hFE); repeat (4) put(8'h00);
    put(CODE_SKIP); put(8'hFF);
    put(8'h80); put_pixel();              // fill of 128 overruns the frame
    put(CODE_EOL);
    put(8'h01); put(CODE_EOL);
    flush_stream();
    drain();

    long_hold = 1;                        // stall output so the queue backs up
    write_frame_size(13'd16, 13'd8);
    random_phase(30, 16'd9, 16'd3);
    drain();

    write_frame_size(13'd1, 13'd1);
    random_phase(15, 16'd1, 16'd2);
    drain();

    write_frame_size(13'd0, 13'd3);       // empty frame: every write flagged
    random_phase(10, 16'd2, 16'd2);
    drain();

    write_frame_size(13'd4096, 13'd4096);
    random_phase(25, 16'hFFFF, 16'd2);
    drain();

    write_frame_size(13'h1FFF, 13'h1FFF); // oversized, clamped to max
    random_phase(15, 16'hFFFF, 16'd2);
    build_frame(1'b0, 16'd0, 16'd0, 0);   // plain header, aborted by next chunk
    flush_stream();
    drain();

    write_frame_size(13'd7, 13'd3);
    put(8'h00, 1'b1); repeat (3) put(8'h00);
    put(8'h00); put(8'h00);               // plain header: 3 lines
    repeat (3) begin
      put(8'h02); put(8'h81); put_pixel(); put(CODE_EOL);
    end
    flush_stream();
    random_phase(30, 16'd4, 16'd3);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
